FILE: design/assert_macros.svh
// Assertion macros shared by the RTL of the palette mapper.
// No dependencies; the files that check their own logic include this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// The property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// The expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

FILE: design/npcm_pkg.sv
// Types, codes and constants of the nearest palette color mapper.
// No dependencies; the front end, queue, back end and top level use it by scoped names.
package npcm_pkg;

  // Palette size and queue depth.
  localparam int unsigned PaletteEntries = 256;
  localparam int unsigned QueueDepth     = 2;

  // Fixed field widths.
  localparam int unsigned ChanW = 8;
  localparam int unsigned IdxW  = 8;
  localparam int unsigned RgbW  = 3 * ChanW;

  // Pixel classification and search bounds.
  localparam logic [ChanW-1:0] AlphaOpaqueFloor = 8'd128;
  localparam logic [IdxW-1:0]  LastFull         = 8'd255;
  localparam logic [IdxW-1:0]  LastNoFullbright = 8'd223;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_TRANSPARENT_INDEX = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ALLOW_FULLBRIGHT  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SKIP_ENTRY_ZERO   = 2'd2;

  // Operation codes of an input beat.
  localparam logic OP_MAP   = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Kind of job handed from the front to the back.
  typedef enum logic [1:0] {
    JOB_WRITE  = 2'd0,
    JOB_TRANSP = 2'd1,
    JOB_SEARCH = 2'd2
  } job_kind_e;

  // Input beat.
  typedef struct packed {
    logic             operation;
    logic [IdxW-1:0]  entry_index;
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] alpha;
  } npcm_in_t;

  // Result beat.
  typedef struct packed {
    logic [IdxW-1:0] palette_index;
    logic            was_transparent;
  } npcm_out_t;

  // Queue entry: write address or transparent index in index, bounds for a search.
  typedef struct packed {
    job_kind_e       kind;
    logic [IdxW-1:0] index;
    logic [IdxW-1:0] first;
    logic [IdxW-1:0] last;
    logic [RgbW-1:0] color;
  } npcm_job_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } npcm_fifo_stat_t;

  // Back end control toward the queue and the top level.
  typedef struct packed {
    logic pop;
    logic idle;
  } npcm_back_ctl_t;

endpackage

FILE: design/npcm_front.sv
// Front end: holds the configuration registers, accepts input beats and
// classifies them into queue jobs. Depends on npcm_pkg.
module npcm_front #(
  parameter int unsigned PALETTE_ENTRIES = npcm_pkg::PaletteEntries
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  npcm_pkg::npcm_in_t               in_i,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [npcm_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [npcm_pkg::IdxW-1:0]        cfg_data_i,
  input  npcm_pkg::npcm_fifo_stat_t        fifo_stat_i,
  output logic                             push_o,
  output npcm_pkg::npcm_job_t              job_o
);

  localparam logic [npcm_pkg::IdxW:0]   EntriesW = (npcm_pkg::IdxW + 1)'(PALETTE_ENTRIES);
  localparam logic [npcm_pkg::IdxW-1:0] LastMax  = npcm_pkg::IdxW'(PALETTE_ENTRIES - 1);

  logic [npcm_pkg::IdxW-1:0] transp_idx_q, transp_idx_d;
  logic                      fullbright_q, fullbright_d;
  logic                      skip_zero_q, skip_zero_d;
  logic                      accept;
  logic                      in_range;
  logic [npcm_pkg::IdxW-1:0] last_lim;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    transp_idx_d = transp_idx_q;
    fullbright_d = fullbright_q;
    skip_zero_d  = skip_zero_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        npcm_pkg::CFG_TRANSPARENT_INDEX: transp_idx_d = cfg_data_i;
        npcm_pkg::CFG_ALLOW_FULLBRIGHT:  fullbright_d = cfg_data_i[0];
        npcm_pkg::CFG_SKIP_ENTRY_ZERO:   skip_zero_d  = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      transp_idx_q <= '0;
      fullbright_q <= 1'b0;
      skip_zero_q  <= 1'b0;
    end else begin
      transp_idx_q <= transp_idx_d;
      fullbright_q <= fullbright_d;
      skip_zero_q  <= skip_zero_d;
    end
  end

  // A beat is taken whenever the queue has room.
  assign busy   = fifo_stat_i.full;
  assign accept = start && !busy;

  // Writes beyond the palette are dropped here and never reach the back end.
  assign in_range = {1'b0, in_i.entry_index} < EntriesW;

  // The search never runs past the last entry of the palette.
  always_comb begin
    last_lim = fullbright_q ? npcm_pkg::LastFull : npcm_pkg::LastNoFullbright;
    if (last_lim > LastMax) begin
      last_lim = LastMax;
    end
  end

  // Classify the beat into a job.
  always_comb begin
    job_o.color = {in_i.red, in_i.green, in_i.blue};
    job_o.first = skip_zero_q ? npcm_pkg::IdxW'(1) : '0;
    job_o.last  = last_lim;
    if (in_i.operation == npcm_pkg::OP_WRITE) begin
      job_o.kind  = npcm_pkg::JOB_WRITE;
      job_o.index = in_i.entry_index;
    end else if (in_i.alpha <= npcm_pkg::AlphaOpaqueFloor) begin
      job_o.kind  = npcm_pkg::JOB_TRANSP;
      job_o.index = transp_idx_q;
    end else begin
      job_o.kind  = npcm_pkg::JOB_SEARCH;
      job_o.index = transp_idx_q;
    end
  end

  assign push_o = accept && ((in_i.operation != npcm_pkg::OP_WRITE) || in_range);

endmodule

FILE: design/npcm_fifo.sv
// Short job queue between the front end and the back end.
// Depends on npcm_pkg for the job type and the depth.
module npcm_fifo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push_i,
  input  npcm_pkg::npcm_job_t       job_i,
  input  logic                      pop_i,
  output npcm_pkg::npcm_job_t       job_o,
  output npcm_pkg::npcm_fifo_stat_t stat_o
);

  localparam int unsigned Depth = npcm_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  npcm_pkg::npcm_job_t slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage slots carry payload only.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  assign job_o        = slot_q[rd_ptr_q];
  assign stat_o.full  = (count_q == CntFull);
  assign stat_o.empty = (count_q == '0);

endmodule

FILE: design/npcm_back.sv
// Back end: palette memory and the one-entry-per-cycle nearest color search.
// Depends on npcm_pkg; takes jobs from npcm_fifo.
module npcm_back #(
  parameter int unsigned PALETTE_ENTRIES = npcm_pkg::PaletteEntries
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  npcm_pkg::npcm_fifo_stat_t fifo_stat_i,
  input  npcm_pkg::npcm_job_t       job_i,
  output npcm_pkg::npcm_back_ctl_t  ctl_o,
  output logic                      result_valid_o,
  output npcm_pkg::npcm_out_t       result_o
);

  localparam int unsigned AddrW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int unsigned SqW   = 2 * npcm_pkg::ChanW;
  localparam int unsigned DistW = SqW + 2;
  localparam int unsigned ChanW = npcm_pkg::ChanW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0] state_q, state_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [AddrW-1:0] last_q, last_d;
  logic [npcm_pkg::RgbW-1:0] pix_q, pix_d;
  logic pop;
  logic mem_we;

  // Memory read stage.
  logic [npcm_pkg::RgbW-1:0] mem_q [PALETTE_ENTRIES];
  logic [npcm_pkg::RgbW-1:0] rd_data_q;
  logic [AddrW-1:0] rd_idx_q, rd_idx_d;
  logic rd_vld_q, rd_vld_d;
  logic rd_last_q, rd_last_d;

  // Square stage.
  logic [ChanW-1:0] dr, dg, db;
  logic [SqW-1:0] sq_r_q, sq_g_q, sq_b_q;
  logic [AddrW-1:0] sq_idx_q;
  logic sq_vld_q, sq_last_q;

  // Compare stage.
  logic [DistW-1:0] sum_sq;
  logic better;
  logic [DistW-1:0] min_sum_q, min_sum_d;
  logic [AddrW-1:0] best_idx_q, best_idx_d;
  logic have_best_q, have_best_d;
  logic res_vld_d;
  npcm_pkg::npcm_out_t res_d, res_q;
  logic res_vld_q;

  // Absolute channel difference.
  function automatic logic [ChanW-1:0] abs_diff(input logic [ChanW-1:0] a,
                                                input logic [ChanW-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

  // Distance of the entry in the compare stage and whether it wins.
  assign sum_sq = DistW'(sq_r_q) + DistW'(sq_g_q) + DistW'(sq_b_q);
  assign better = !have_best_q || (sum_sq < min_sum_q);

  // Sequencer: takes jobs, issues one read per cycle during a search.
  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    last_d      = last_q;
    pix_d       = pix_q;
    pop         = 1'b0;
    mem_we      = 1'b0;
    rd_vld_d    = 1'b0;
    rd_last_d   = 1'b0;
    rd_idx_d    = addr_q;
    min_sum_d   = min_sum_q;
    best_idx_d  = best_idx_q;
    have_best_d = have_best_q;
    res_vld_d   = 1'b0;
    res_d       = res_q;

    unique case (state_q)
      ST_IDLE: begin
        if (!fifo_stat_i.empty) begin
          pop = 1'b1;
          case (job_i.kind)
            npcm_pkg::JOB_WRITE: begin
              mem_we = 1'b1;
            end
            npcm_pkg::JOB_TRANSP: begin
              res_vld_d             = 1'b1;
              res_d.palette_index   = job_i.index;
              res_d.was_transparent = 1'b1;
            end
            default: begin
              addr_d      = job_i.first[AddrW-1:0];
              last_d      = job_i.last[AddrW-1:0];
              pix_d       = job_i.color;
              have_best_d = 1'b0;
              state_d     = ST_SCAN;
            end
          endcase
        end
      end
      ST_SCAN: begin
        rd_vld_d  = 1'b1;
        rd_last_d = (addr_q == last_q);
        if (addr_q == last_q) begin
          state_d = ST_WAIT;
        end else begin
          addr_d = addr_q + AddrW'(1);
        end
      end
      ST_WAIT: begin
        if (sq_vld_q && sq_last_q) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Running minimum; the lowest index wins ties since only a smaller distance replaces.
    if (sq_vld_q) begin
      have_best_d = 1'b1;
      if (better) begin
        min_sum_d  = sum_sq;
        best_idx_d = sq_idx_q;
      end
      if (sq_last_q) begin
        res_vld_d             = 1'b1;
        res_d.palette_index   = npcm_pkg::IdxW'(better ? sq_idx_q : best_idx_q);
        res_d.was_transparent = 1'b0;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_vld_q    <= 1'b0;
      sq_vld_q    <= 1'b0;
      have_best_q <= 1'b0;
      res_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_vld_q    <= rd_vld_d;
      sq_vld_q    <= rd_vld_q;
      have_best_q <= have_best_d;
      res_vld_q   <= res_vld_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    addr_q      <= addr_d;
    last_q      <= last_d;
    pix_q       <= pix_d;
    rd_idx_q    <= rd_idx_d;
    rd_last_q   <= rd_last_d;
    sq_idx_q    <= rd_idx_q;
    sq_last_q   <= rd_last_q;
    sq_r_q      <= SqW'(dr) * SqW'(dr);
    sq_g_q      <= SqW'(dg) * SqW'(dg);
    sq_b_q      <= SqW'(db) * SqW'(db);
    min_sum_q   <= min_sum_d;
    best_idx_q  <= best_idx_d;
    res_q       <= res_d;
  end

  // Palette memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[job_i.index[AddrW-1:0]] <= job_i.color;
    end
    rd_data_q <= mem_q[addr_q];
  end

  // Channel differences of the entry just read.
  assign dr = abs_diff(pix_q[3*ChanW-1:2*ChanW], rd_data_q[3*ChanW-1:2*ChanW]);
  assign dg = abs_diff(pix_q[2*ChanW-1:ChanW],   rd_data_q[2*ChanW-1:ChanW]);
  assign db = abs_diff(pix_q[ChanW-1:0],         rd_data_q[ChanW-1:0]);

  assign ctl_o.pop       = pop;
  assign ctl_o.idle      = (state_q == ST_IDLE);
  assign result_valid_o  = res_vld_q;
  assign result_o        = res_q;

endmodule

FILE: design/nearest_palette_color_mapper_core.sv
// Top level of the nearest palette color mapper: front end, job queue, back end.
// Depends on npcm_pkg, npcm_front, npcm_fifo, npcm_back and assert_macros.svh.
//
// Use: load every palette entry with write beats (operation 1) before the first
// map beat (operation 0). A beat is taken on a rising edge with start high and
// busy low. The user is to write the configuration registers over the cfg channel (index,
// data) only while the block is idle; the block does not enforce this. The channel is always ready.
// Each map beat returns one result on result_o, marked by result_valid_o for a
// single cycle; write beats return nothing. Results come back in beat order.
// A transparent pixel's result appears in the cycle after the back end pops it.
// An opaque pixel scans the allowed entries at one palette memory read per cycle; each
// entry passes the read, square and compare stages, and the result is registered once
// the last entry is compared, as the back end returns to idle. A write is stored into
// the palette memory in the cycle of its pop.
// The two-entry job queue lets new beats be taken while a search runs; busy
// rises when that queue is full.
// Reset clears the configuration to zero and empties the queue and pipeline;
// palette contents are not cleared and stay undefined until written.
// The receiver cannot stall: results are never held back.
`include "assert_macros.svh"

module nearest_palette_color_mapper_core #(
  parameter int unsigned PALETTE_ENTRIES = npcm_pkg::PaletteEntries
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  npcm_pkg::npcm_in_t           in_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [npcm_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [npcm_pkg::IdxW-1:0]    cfg_data_i,
  output logic                         result_valid_o,
  output npcm_pkg::npcm_out_t          result_o
);

  npcm_pkg::npcm_fifo_stat_t fifo_stat;
  npcm_pkg::npcm_back_ctl_t  back_ctl;
  npcm_pkg::npcm_job_t       push_job;
  npcm_pkg::npcm_job_t       head_job;
  logic                      push;

  // Accept and classify beats.
  npcm_front #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .in_i        (in_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .job_o       (push_job)
  );

  // Job queue between the two sides.
  npcm_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (back_ctl.pop),
    .job_o  (head_job),
    .stat_o (fifo_stat)
  );

  // Palette memory and search.
  npcm_back #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fifo_stat_i    (fifo_stat),
    .job_i          (head_job),
    .ctl_o          (back_ctl),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  // Queue is never written when full nor read when empty.
  `ASSERT_NEVER(a_push_full, clk_i, rst_ni, push && fifo_stat.full, "job queue overflow")
  `ASSERT_NEVER(a_pop_empty, clk_i, rst_ni, back_ctl.pop && fifo_stat.empty, "job queue underflow")
  // A result only follows a job taken from the queue or a search in progress.
  `ASSERT_PROP(a_result_src, clk_i, rst_ni, result_valid_o |-> $past(back_ctl.pop || !back_ctl.idle), "result without a job")

endmodule

FILE: tb/npcm_result_checker.sv
// Result checker for the nearest palette color mapper: predicts every map beat and compares.
// Depends on npcm_pkg; watches the beat, configuration and result channels of the core.
module npcm_result_checker
  import npcm_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = npcm_pkg::PaletteEntries
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  npcm_in_t            beat_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [IdxW-1:0]     cfg_data_i,
  input  logic                result_valid_i,
  input  npcm_out_t           result_i,
  output int                  mismatch_count_o,
  output int                  pending_count_o,
  output int                  results_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  // Distance that any real palette entry beats.
  localparam int unsigned DistCeiling = 1 << 30;

  // Shadow of the palette and of the configuration registers.
  logic [RgbW-1:0] palette_copy [PALETTE_ENTRIES];
  logic [IdxW-1:0] transp_idx;
  logic            fullbright_on;
  logic            skip_zero;

  // Results owed by the core, oldest first.
  npcm_out_t       owed_results [$];
  npcm_out_t       want;
  npcm_out_t       fresh;
  int              mismatches;
  int              results_seen;

  // Least squared RGB distance over the allowed range; the lowest index wins a tie.
  function automatic logic [IdxW-1:0] nearest_entry(input logic [ChanW-1:0] r,
                                                    input logic [ChanW-1:0] g,
                                                    input logic [ChanW-1:0] b);
    int unsigned lo, hi, pick, lead_sum, sum_sq, i;
    int          dr, dg, db;
    logic        hit;
    lo = skip_zero ? 1 : 0;
    hi = fullbright_on ? int'(LastFull) : int'(LastNoFullbright);
    if (hi > PALETTE_ENTRIES - 1) hi = PALETTE_ENTRIES - 1;
    pick = lo;
    lead_sum = DistCeiling;
    hit = 1'b0;
    for (i = lo; i <= hi && !hit; i++) begin
      dr = int'(r) - int'(palette_copy[i][23:16]);
      dg = int'(g) - int'(palette_copy[i][15:8]);
      db = int'(b) - int'(palette_copy[i][7:0]);
      sum_sq = dr * dr + dg * dg + db * db;
      // An exact match ends the scan.
      if (sum_sq == 0) begin
        pick = i;
        hit = 1'b1;
      end else if (sum_sq < lead_sum) begin
        lead_sum = sum_sq;
        pick = i;
      end
    end
    return pick[IdxW-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      transp_idx    = '0;
      fullbright_on = 1'b0;
      skip_zero     = 1'b0;
      owed_results.delete();
      mismatches    = 0;
      results_seen  = 0;
      mismatch_count_o <= 0;
      pending_count_o  <= 0;
      results_seen_o   <= 0;
    end else begin
      // Register writes land in the shadow copy.
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_TRANSPARENT_INDEX: transp_idx = cfg_data_i;
          CFG_ALLOW_FULLBRIGHT:  fullbright_on = cfg_data_i[0];
          CFG_SKIP_ENTRY_ZERO:   skip_zero = cfg_data_i[0];
          default: ;
        endcase
      end

      // A result beat is matched against the oldest owed result.
      if (result_valid_i) begin
        results_seen++;
        if (owed_results.size() == 0) begin
          $error("unexpected result beat: palette_index %0d, was_transparent %0b",
                 result_i.palette_index, result_i.was_transparent);
          mismatches++;
        end else begin
          want = owed_results.pop_front();
          if (result_i.palette_index !== want.palette_index) begin
            $error("palette_index: expected %0d, actual %0d",
                   want.palette_index, result_i.palette_index);
            mismatches++;
          end
          if (result_i.was_transparent !== want.was_transparent) begin
            $error("was_transparent: expected %0b, actual %0b",
                   want.was_transparent, result_i.was_transparent);
            mismatches++;
          end
        end
      end

      // An accepted beat either updates the palette or owes one result.
      if (start_i && !busy_i) begin
        if (beat_i.operation == OP_WRITE) begin
          if (beat_i.entry_index < PALETTE_ENTRIES) begin
            palette_copy[beat_i.entry_index] = {beat_i.red, beat_i.green, beat_i.blue};
          end
        end else if (beat_i.alpha <= AlphaOpaqueFloor) begin
          fresh.palette_index   = transp_idx;
          fresh.was_transparent = 1'b1;
          owed_results.push_back(fresh);
        end else begin
          fresh.palette_index   = nearest_entry(beat_i.red, beat_i.green, beat_i.blue);
          fresh.was_transparent = 1'b0;
          owed_results.push_back(fresh);
        end
      end

      mismatch_count_o <= mismatches;
      pending_count_o  <= owed_results.size();
      results_seen_o   <= results_seen;
    end
  end

endmodule

FILE: tb/tb_nearest_palette_color_mapper_core.sv
// Testbench top for nearest_palette_color_mapper_core: loads the palette, drives map beats.
// Depends on npcm_pkg, the core and npcm_result_checker, which predicts and compares.
module tb_nearest_palette_color_mapper_core;
  timeunit 1ns;
  timeprecision 1ps;
  import npcm_pkg::*;

  localparam int unsigned Entries       = PaletteEntries;
  localparam int unsigned ItemsPerPhase = 160;
  localparam int unsigned DrainCycles   = 300;
  localparam int unsigned CycleLimit    = 1_500_000;

  // Share of cycles in which the sender idles, one value per phase.
  localparam int IdlePct [4] = '{0, 67, 0, 22};

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  npcm_in_t            in_i;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [IdxW-1:0]     cfg_data_i;
  logic                result_valid_o;
  npcm_out_t           result_o;

  int                  mismatch_count;
  int                  pending_count;
  int                  results_seen;

  int                  idle_pct;
  int                  write_beats;
  int                  map_beats;
  int                  settings_applied;
  int unsigned         cycle_count;

  // Colors the stimulus has written, used to aim pixels at entries.
  logic [RgbW-1:0]     shade [Entries];

  nearest_palette_color_mapper_core #(
    .PALETTE_ENTRIES(Entries)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .in_i          (in_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  npcm_result_checker #(
    .PALETTE_ENTRIES(Entries)
  ) u_result_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .beat_i          (in_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .result_valid_i  (result_valid_o),
    .result_i        (result_o),
    .mismatch_count_o(mismatch_count),
    .pending_count_o (pending_count),
    .results_seen_o  (results_seen)
  );

  // Free-running clock, 20 ns period.
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Watchdog against a hung core.
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // A map beat; the unused entry index carries noise.
  function automatic npcm_in_t make_map(input logic [RgbW-1:0] rgb, input logic [ChanW-1:0] a);
    npcm_in_t b;
    b.operation   = OP_MAP;
    b.entry_index = IdxW'($urandom_range(255));
    {b.red, b.green, b.blue} = rgb;
    b.alpha       = a;
    return b;
  endfunction

  // A palette write beat; the ignored alpha carries noise.
  function automatic npcm_in_t make_write(input logic [IdxW-1:0] idx,
                                          input logic [RgbW-1:0] rgb);
    npcm_in_t b;
    b.operation   = OP_WRITE;
    b.entry_index = idx;
    {b.red, b.green, b.blue} = rgb;
    b.alpha       = ChanW'($urandom_range(255));
    return b;
  endfunction

  // Offers one beat after a random gap and returns at the edge that takes it.
  task automatic send_beat(input npcm_in_t b);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    in_i  <= b;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (b.operation == OP_WRITE) write_beats++;
    else map_beats++;
  endtask

  // Waits until every owed result has come back and any trailing write has retired.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // One register write beat; valid stays high for a following write.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [IdxW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // Writes all three registers once the core is idle.
  task automatic apply_setting(input logic [IdxW-1:0] transp, input logic fullbright,
                               input logic skip0);
    wait_idle();
    write_reg(CFG_TRANSPARENT_INDEX, transp);
    write_reg(CFG_ALLOW_FULLBRIGHT, {7'd0, fullbright});
    write_reg(CFG_SKIP_ENTRY_ZERO, {7'd0, skip0});
    cfg_valid_i <= 1'b0;
    settings_applied++;
  endtask

  initial begin
    logic [RgbW-1:0]  rgb;
    logic [ChanW-1:0] alpha;
    logic [IdxW-1:0]  idx;
    int               v;

    rst_ni           = 1'b0;
    start            = 1'b0;
    in_i             = '0;
    cfg_valid_i      = 1'b0;
    cfg_index_i      = '0;
    cfg_data_i       = '0;
    idle_pct         = 0;
    write_beats      = 0;
    map_beats        = 0;
    settings_applied = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Load every entry before the first map beat, with a few entries pinned.
    for (int i = 0; i < Entries; i++) begin
      case (i)
        0:       rgb = 24'h000000;
        10, 20:  rgb = 24'h406080;
        223:     rgb = 24'h10F0A0;
        224:     rgb = 24'h10F0A1;
        255:     rgb = 24'hFFFFFF;
        default: rgb = RgbW'($urandom_range(24'hFFFFFF));
      endcase
      shade[i] = rgb;
      send_beat(make_write(i[IdxW-1:0], rgb));
    end

    // Directed beats under the reset configuration.
    send_beat(make_map(24'h000000, 8'd255));    // exact match on entry zero
    send_beat(make_map(24'hFFFFFF, 8'd255));    // white while the top entries are excluded
    send_beat(make_map(24'h406080, 8'd200));    // tie between two entries
    send_beat(make_map(24'h10F0A1, 8'd129));    // exact only in the excluded range
    send_beat(make_map(24'h10F0A0, 8'd255));
    send_beat(make_map(24'h123456, 8'd128));    // alpha at the transparent bound
    send_beat(make_map(24'h123456, 8'd0));
    send_beat(make_map(24'hFF0000, 8'd255));
    send_beat(make_map(24'h00FF00, 8'd255));
    send_beat(make_map(24'h0000FF, 8'd255));
    shade[5] = 24'h406080;
    send_beat(make_write(8'd5, 24'h406080));    // a lower entry joins the tie
    send_beat(make_map(24'h406080, 8'd255));

    // Directed beats with every register at its top value.
    apply_setting(8'd255, 1'b1, 1'b1);
    send_beat(make_map(24'h000000, 8'd255));    // entry zero now skipped
    send_beat(make_map(24'hFFFFFF, 8'd255));
    send_beat(make_map(24'h10F0A1, 8'd255));
    send_beat(make_map(24'h123456, 8'd128));
    send_beat(make_map(24'h654321, 8'd64));

    // Random phases, each with its own register setting and sender pacing.
    for (int p = 0; p < 4; p++) begin
      case (p)
        0:       apply_setting(8'd0, 1'b0, 1'b0);
        1:       apply_setting(8'd255, 1'b1, 1'b1);
        2:       apply_setting(IdxW'($urandom_range(255)), 1'b1, 1'b0);
        default: apply_setting(IdxW'($urandom_range(255)), 1'b0, 1'b1);
      endcase
      idle_pct = IdlePct[p];
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if ($urandom_range(99) < 20) begin
          // Rewrite an entry, sometimes with the color of another to force ties.
          idx = IdxW'($urandom_range(255));
          if ($urandom_range(3) == 0) rgb = shade[$urandom_range(255)];
          else rgb = RgbW'($urandom_range(24'hFFFFFF));
          shade[idx] = rgb;
          send_beat(make_write(idx, rgb));
        end else begin
          case ($urandom_range(7))
            0:       alpha = 8'd128;
            1:       alpha = 8'd129;
            2:       alpha = ChanW'($urandom_range(127));
            3:       alpha = 8'd0;
            4:       alpha = 8'd255;
            default: alpha = ChanW'($urandom_range(255, 129));
          endcase
          // Aim at the range bounds more often than chance would.
          case ($urandom_range(9))
            0:       idx = 8'd0;
            1:       idx = 8'd1;
            2:       idx = LastNoFullbright;
            3:       idx = LastNoFullbright + 8'd1;
            4:       idx = LastFull;
            default: idx = IdxW'($urandom_range(255));
          endcase
          v = $urandom_range(99);
          if (v < 35) begin
            rgb = shade[idx];
          end else if (v < 60) begin
            // Nudge each channel of an entry by a few steps.
            rgb = shade[idx];
            for (int c = 0; c < 3; c++) begin
              v = int'(rgb[c*8 +: 8]) + int'($urandom_range(6)) - 3;
              if (v < 0) v = 0;
              if (v > 255) v = 255;
              rgb[c*8 +: 8] = v[7:0];
            end
          end else begin
            rgb = RgbW'($urandom_range(24'hFFFFFF));
          end
          send_beat(make_map(rgb, alpha));
        end
      end
    end

    wait_idle();
    $display("Drove %0d palette writes and %0d pixel maps under %0d register settings.",
             write_beats, map_beats, settings_applied);
    $display("Checked %0d results; %0d mismatches, %0d still owed.",
             results_seen, mismatch_count, pending_count);
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
